// ----- design/sync_length_checksum_deframer_defines.svh -----
// assertion macros shared by the deframer modules
`ifndef SYNC_LENGTH_CHECKSUM_DEFRAMER_DEFINES_SVH
`define SYNC_LENGTH_CHECKSUM_DEFRAMER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SLCD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("slcd assertion failed");

// next-cycle implication, disabled while in reset
`define SLCD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("slcd assertion failed");

`endif

// ----- design/slcd_pkg.sv -----
// types and constants of the sync / length / checksum deframer
`default_nettype none

package slcd_pkg;

	localparam logic [7:0]  SYNC_BYTE       = 8'hAA;
	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd10;

	typedef enum logic [1:0] {
		KIND_OPCODE  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_END     = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_SUM  = 2'd1,
		ST_ZERO_LEN = 2'd2,
		ST_TRUNC    = 2'd3
	} status_t;

	typedef enum logic [5:0] {
		PH_HUNT    = 6'b000001,
		PH_LEN_H   = 6'b000010,
		PH_LEN_L   = 6'b000100,
		PH_OPCODE  = 6'b001000,
		PH_PAYLOAD = 6'b010000,
		PH_CHECK   = 6'b100000
	} phase_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  value;
		status_t     status;
		logic [15:0] byte_index;
	} res_t;

	typedef struct packed {
		logic valid;
		res_t res;
	} res_push_t;

endpackage

`default_nettype wire

// ----- design/slcd_parser.sv -----
// frame parser: phase machine, length / count tracking and checksum
`default_nettype none
`include "sync_length_checksum_deframer_defines.svh"

module slcd_parser (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               byte_valid,
	input  wire logic [7:0]         byte_in,
	output slcd_pkg::res_push_t     push
);

	slcd_pkg::phase_t phase_q, phase_d;
	logic [7:0]  len_hi_q, len_hi_d;
	logic [15:0] left_q, left_d;
	logic [15:0] count_q, count_d;
	logic [7:0]  sum_q, sum_d;
	logic        trunc_q, trunc_d;
	logic [15:0] max_payload_q;

	logic [7:0]  sum_next;
	logic [15:0] length;
	logic [15:0] left_dec;

	assign sum_next = sum_q + byte_in;
	assign length   = {len_hi_q, byte_in};
	assign left_dec = left_q - 16'd1;

	always_comb begin
		phase_d  = phase_q;
		len_hi_d = len_hi_q;
		left_d   = left_q;
		count_d  = count_q;
		sum_d    = sum_q;
		trunc_d  = trunc_q;
		push.valid          = 1'b0;
		push.res.kind       = slcd_pkg::KIND_END;
		push.res.value      = 8'd0;
		push.res.status     = slcd_pkg::ST_OK;
		push.res.byte_index = 16'd0;
		unique case (phase_q)
			slcd_pkg::PH_LEN_H: begin
				len_hi_d = byte_in;
				sum_d    = sum_next;
				phase_d  = slcd_pkg::PH_LEN_L;
			end
			slcd_pkg::PH_LEN_L: begin
				sum_d = sum_next;
				if (length == 16'd0) begin
					phase_d         = slcd_pkg::PH_HUNT;
					push.valid      = 1'b1;
					push.res.status = slcd_pkg::ST_ZERO_LEN;
				end else begin
					left_d  = length - 16'd1;
					count_d = 16'd0;
					trunc_d = 1'b0;
					phase_d = slcd_pkg::PH_OPCODE;
				end
			end
			slcd_pkg::PH_OPCODE: begin
				sum_d   = sum_next;
				phase_d = (left_q != 16'd0) ? slcd_pkg::PH_PAYLOAD : slcd_pkg::PH_CHECK;
				push.valid     = 1'b1;
				push.res.kind  = slcd_pkg::KIND_OPCODE;
				push.res.value = byte_in;
			end
			slcd_pkg::PH_PAYLOAD: begin
				sum_d   = sum_next;
				count_d = count_q + 16'd1;
				left_d  = left_dec;
				if (left_dec == 16'd0) begin
					phase_d = slcd_pkg::PH_CHECK;
				end
				if (count_q < max_payload_q) begin
					push.valid          = 1'b1;
					push.res.kind       = slcd_pkg::KIND_PAYLOAD;
					push.res.value      = byte_in;
					push.res.byte_index = count_q;
				end else begin
					trunc_d = 1'b1;
				end
			end
			slcd_pkg::PH_CHECK: begin
				sum_d      = sum_next;
				phase_d    = slcd_pkg::PH_HUNT;
				push.valid = 1'b1;
				if (sum_next != 8'd0) begin
					push.res.status = slcd_pkg::ST_BAD_SUM;
				end else if (trunc_q) begin
					push.res.status = slcd_pkg::ST_TRUNC;
				end else begin
					push.res.status = slcd_pkg::ST_OK;
				end
			end
			default: begin
				// hunting, and any unused phase code
				phase_d = slcd_pkg::PH_HUNT;
				if (byte_in == slcd_pkg::SYNC_BYTE) begin
					sum_d    = 8'd0;
					len_hi_d = 8'd0;
					left_d   = 16'd0;
					count_d  = 16'd0;
					trunc_d  = 1'b0;
					phase_d  = slcd_pkg::PH_LEN_H;
				end
			end
		endcase
		if (!byte_valid) begin
			push.valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= slcd_pkg::PH_HUNT;
			len_hi_q <= 8'd0;
			left_q   <= 16'd0;
			count_q  <= 16'd0;
			sum_q    <= 8'd0;
			trunc_q  <= 1'b0;
		end else if (byte_valid) begin
			phase_q  <= phase_d;
			len_hi_q <= len_hi_d;
			left_q   <= left_d;
			count_q  <= count_d;
			sum_q    <= sum_d;
			trunc_q  <= trunc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= slcd_pkg::MAX_PAYLOAD_RST;
		end else if (cfg_we) begin
			max_payload_q <= cfg_data;
		end
	end

	`SLCD_ASSERT_NOW(a_payload_within_max, clk, arst_n,
		push.valid && push.res.kind == slcd_pkg::KIND_PAYLOAD,
		push.res.byte_index < max_payload_q)
	`SLCD_ASSERT_NOW(a_end_value_zero, clk, arst_n,
		push.valid && push.res.kind == slcd_pkg::KIND_END,
		push.res.value == 8'd0 && push.res.byte_index == 16'd0)
	`SLCD_ASSERT_NEXT(a_end_returns_hunt, clk, arst_n,
		push.valid && push.res.kind == slcd_pkg::KIND_END,
		phase_q == slcd_pkg::PH_HUNT)

endmodule

`default_nettype wire

// ----- design/slcd_out_fifo.sv -----
// two-entry result queue in front of the master stream port
`default_nettype none
`include "sync_length_checksum_deframer_defines.svh"

module slcd_out_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire slcd_pkg::res_push_t push,
	output logic                    full,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output slcd_pkg::res_t          out_res
);

	slcd_pkg::res_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign full      = (count_q == 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign out_res   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.valid) begin
			entry_q[wr_ptr_q] <= push.res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push.valid, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	`SLCD_ASSERT_NOW(a_no_push_when_full, clk, arst_n, push.valid, !full)
	`SLCD_ASSERT_NEXT(a_count_up, clk, arst_n, push.valid && !pop,
		count_q == $past(count_q) + 2'd1)
	`SLCD_ASSERT_NEXT(a_count_down, clk, arst_n, pop && !push.valid,
		count_q == $past(count_q) - 2'd1)

endmodule

`default_nettype wire

// ----- design/sync_length_checksum_deframer.sv -----
// top level of the sync / length / checksum deframer
//
// channel   dir  handshake             payload
// s_*       in   s_tvalid / s_tready   s_tdata[7:0] rx_byte
// m_*       out  m_tvalid / m_tready   m_tdata value, status, byte_index; m_tuser item_kind
// cfg_*     in   cfg_valid / cfg_ready cfg_data max_payload
//
// one byte per cycle unless the queue is full: input register, single-pass parser, queue
// a result is registered in the queue and shown on m_tvalid after its byte leaves s1
// arst_n clears phase, counters, sum, queue and sets max_payload to 10
// a stalled m_tready fills the two-entry queue, then s_tready drops for the s1 byte
// cfg_ready is always high; writes are meant for idle periods between frames
`default_nettype none

module sync_length_checksum_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [7:0] value, [9:8] status, [25:10] byte_index, rest 0
	output logic [1:0]       m_tuser,   // [1:0] item_kind
	// configuration
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data   // [15:0] max_payload
);

	// input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       fifo_full;

	slcd_pkg::res_push_t push;
	slcd_pkg::res_t      out_res;

	// the s1 byte moves into the parser whenever the queue has room
	assign advance   = valid_s1 && !fifo_full;
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	slcd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.byte_valid (advance),
		.byte_in    (byte_s1),
		.push       (push)
	);

	slcd_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (fifo_full),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	// pack result fields from the lowest bit up, zero fill to 32 bits
	assign m_tdata = {6'd0, out_res.byte_index, out_res.status, out_res.value};
	assign m_tuser = out_res.kind;

endmodule

`default_nettype wire
